### rtl/core/line_vanishing_point_classifier_top_defines.svh
// Assertion macros for the vanishing point classifier
`ifndef LINE_VANISHING_POINT_CLASSIFIER_TOP_DEFINES_SVH
`define LINE_VANISHING_POINT_CLASSIFIER_TOP_DEFINES_SVH

// Concurrent check on a given clock, held off while reset is low
`define LVPC_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the block clock and reset
`define LVPC_ASSERT(lbl, prop, msg) `LVPC_PROP(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/lvpc_pkg.sv
`default_nettype none

package lvpc_pkg;

  // Field and register widths
  localparam int CoordW   = 16;
  localparam int IdxW     = 16;
  localparam int VpW      = 32;
  localparam int ThrW     = 16;
  localparam int ThrFrac  = 15;
  localparam int NumVp    = 3;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int ClusterW = 2;

  localparam logic [ThrW-1:0] ThrReset = 16'd32589;

  // Datapath widths
  localparam int DiffW = CoordW + 1;          // start - end, signed
  localparam int WvW   = VpW + 2;             // 2*vp - (start + end), signed
  localparam int ProdW = DiffW + WvW;         // d * w term
  localparam int DotW  = ProdW + 1;           // dot product
  localparam int MagW  = ProdW;               // |dot|
  localparam int PLoW  = 26;
  localparam int PHiW  = MagW - PLoW;
  localparam int P2W   = 2 * MagW;            // dot squared
  localparam int SqW   = 2 * WvW - 2;         // one component of |w|^2
  localparam int QW    = SqW + 1;             // |w|^2
  localparam int DsqW  = 2 * CoordW;          // one component of |d|^2
  localparam int D2W   = DsqW + 1;            // |d|^2
  localparam int T2W   = 2 * ThrW;            // threshold squared
  localparam int TdW   = T2W + D2W;           // T^2 * |d|^2

  // Wide multiplier split into limbs
  localparam int LimbW  = 34;
  localparam int ALimbs = 3;
  localparam int BLimbs = 2;
  localparam int MulAW  = ALimbs * LimbW;
  localparam int MulBW  = QW;
  localparam int MulPW  = MulAW + MulBW;
  localparam int PpW    = 2 * LimbW;

  localparam int NumStg = 15;

  // Vanishing point numbers
  localparam logic [ClusterW-1:0] Vp0 = 2'd0;
  localparam logic [ClusterW-1:0] Vp1 = 2'd1;
  localparam logic [ClusterW-1:0] Vp2 = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgVp0X = 3'd0,
    CfgVp0Y = 3'd1,
    CfgVp1X = 3'd2,
    CfgVp1Y = 3'd3,
    CfgVp2X = 3'd4,
    CfgVp2Y = 3'd5,
    CfgThr  = 3'd6
  } cfg_reg_e;

endpackage

`default_nettype wire

### rtl/core/lvpc_if.sv
`default_nettype none

// Segment item channel
interface lvpc_seg_if import lvpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] start_x;
  logic [CoordW-1:0] start_y;
  logic [CoordW-1:0] end_x;
  logic [CoordW-1:0] end_y;
  logic [IdxW-1:0]   segment_index;

  modport source (output valid, start_x, start_y, end_x, end_y, segment_index,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, segment_index,
                output ready);
endinterface

// Classification result channel
interface lvpc_res_if import lvpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IdxW-1:0]     result_index;
  logic                assigned;
  logic [ClusterW-1:0] cluster;

  modport source (output valid, result_index, assigned, cluster, input ready);
  modport sink (input valid, result_index, assigned, cluster, output ready);
endinterface

`default_nettype wire

### rtl/core/lvpc_wide_mul.sv
`default_nettype none

// Two-stage unsigned multiplier: limb products, then the aligned sum
module lvpc_wide_mul import lvpc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_pp_i,
  input  wire logic             en_sum_i,
  input  wire logic [MulAW-1:0] a_i,
  input  wire logic [MulBW-1:0] b_i,
  output logic      [MulPW-1:0] prod_o
);

  logic [BLimbs*LimbW-1:0] b_ext;
  logic [PpW-1:0]          pp_q [ALimbs][BLimbs];
  logic [MulPW-1:0]        sum_d;
  logic [MulPW-1:0]        sum_q;

  assign b_ext = {{(BLimbs*LimbW-MulBW){1'b0}}, b_i};

  // Form limb products
  always_ff @(posedge clk_i) begin
    if (en_pp_i) begin
      for (int i = 0; i < ALimbs; i++) begin
        for (int k = 0; k < BLimbs; k++) begin
          pp_q[i][k] <= PpW'(a_i[i*LimbW +: LimbW]) * PpW'(b_ext[k*LimbW +: LimbW]);
        end
      end
    end
  end

  // Add limb products at their offsets
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < ALimbs; i++) begin
      for (int k = 0; k < BLimbs; k++) begin
        sum_d = sum_d + (MulPW'(pp_q[i][k]) << (LimbW * (i + k)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      sum_q <= sum_d;
    end
  end

  assign prod_o = sum_q;

endmodule

`default_nettype wire

### rtl/core/line_vanishing_point_classifier_top.sv
// Channel   Dir  Handshake     Payload
// seg_i     in   valid/ready   start_x, start_y, end_x, end_y, segment_index
// res_o     out  valid/ready   result_index, assigned, cluster
// cfg       in   cfg_we_i      cfg_index_i, cfg_data_i (no read-back)
//
// One segment enters per clock unless the output stalls it back; the result is
// carried by the fifteen register stages (dot products, squares, two limb-split
// compares of 169-bit cross products and a limb-split threshold product).
// Each stage holds only when it is full and the stage after it holds, so
// bubbles fill while the output waits. Reset clears valid bits and sets the
// registers to their defaults; no clearing pass is needed.
`default_nettype none

`include "line_vanishing_point_classifier_top_defines.svh"

module line_vanishing_point_classifier_top import lvpc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  lvpc_seg_if.sink                 seg_i,
  lvpc_res_if.source               res_o
);

  typedef struct packed {
    logic [IdxW-1:0]              idx;
    logic                         zero;
    logic [NumVp-1:0]             skip;
    logic [TdW-1:0]               td;
    logic [NumVp-1:0][P2W-1:0]    p2;
    logic [NumVp-1:0][QW-1:0]     q;
  } cand_t;

  typedef struct packed {
    logic [IdxW-1:0]     idx;
    logic                zero;
    logic                have;
    logic [ClusterW-1:0] best;
    logic [P2W-1:0]      p2b;
    logic [QW-1:0]       qb;
    logic [P2W-1:0]      p2c;
    logic [QW-1:0]       qc;
    logic                skipc;
    logic [TdW-1:0]      td;
  } best_t;

  typedef struct packed {
    logic [IdxW-1:0]     idx;
    logic                zero;
    logic                have;
    logic [ClusterW-1:0] best;
    logic [P2W-1:0]      p2b;
    logic [QW-1:0]       qb;
    logic [TdW-1:0]      td;
  } fin_t;

  // Configuration registers
  logic signed [VpW-1:0] vp_x_q [NumVp];
  logic signed [VpW-1:0] vp_y_q [NumVp];
  logic [ThrW-1:0]       thr_q;

  // Pipeline control
  logic [NumStg:1] v_q;
  logic [NumStg:1] v_in;
  logic [NumStg:1] en;

  // Stage 1
  logic [DiffW-1:0]        sum_x, sum_y;
  logic [IdxW-1:0]         s1_idx;
  logic                    s1_zero;
  logic signed [DiffW-1:0] s1_dx, s1_dy;
  logic signed [WvW-1:0]   s1_wx [NumVp];
  logic signed [WvW-1:0]   s1_wy [NumVp];

  // Stage 2
  logic [IdxW-1:0]         s2_idx;
  logic                    s2_zero;
  logic signed [ProdW-1:0] s2_pxa [NumVp];
  logic signed [ProdW-1:0] s2_pya [NumVp];
  logic [SqW-1:0]          s2_sqx [NumVp];
  logic [SqW-1:0]          s2_sqy [NumVp];
  logic [NumVp-1:0]        s2_skip;
  logic [DsqW-1:0]         s2_dx2, s2_dy2;
  logic [T2W-1:0]          s2_t2;

  // Stage 3
  logic [IdxW-1:0]        s3_idx;
  logic                   s3_zero;
  logic signed [DotW-1:0] s3_p [NumVp];
  logic [QW-1:0]          s3_q [NumVp];
  logic [NumVp-1:0]       s3_skip;
  logic [D2W-1:0]         s3_d2;
  logic [T2W-1:0]         s3_t2;

  // Stage 4
  logic [IdxW-1:0]  s4_idx;
  logic             s4_zero;
  logic [MagW-1:0]  s4_pm [NumVp];
  logic [QW-1:0]    s4_q [NumVp];
  logic [NumVp-1:0] s4_skip;
  logic [TdW-1:0]   s4_td;

  // Stage 5
  logic [IdxW-1:0]      s5_idx;
  logic                 s5_zero;
  logic [2*PLoW-1:0]    s5_ll [NumVp];
  logic [PLoW+PHiW-1:0] s5_lh [NumVp];
  logic [2*PHiW-1:0]    s5_hh [NumVp];
  logic [QW-1:0]        s5_q [NumVp];
  logic [NumVp-1:0]     s5_skip;
  logic [TdW-1:0]       s5_td;

  // Stages 6 to 15
  cand_t            c6_q, c7_q, c8_q;
  best_t            b9_d, b9_q, b10_q, b11_q;
  fin_t             f12_d, f12_q, f13_q, f14_q;
  logic [MulPW-1:0] prod_a, prod_b, prod_c, prod_d, prod_e;
  logic             take1, take2, gt01, gt2;
  logic [MulPW-1:0] lhs;
  logic [IdxW-1:0]     s15_idx;
  logic                s15_assigned;
  logic [ClusterW-1:0] s15_cluster;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumVp; j++) begin
        vp_x_q[j] <= '0;
        vp_y_q[j] <= '0;
      end
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgVp0X: vp_x_q[0] <= cfg_data_i;
        CfgVp0Y: vp_y_q[0] <= cfg_data_i;
        CfgVp1X: vp_x_q[1] <= cfg_data_i;
        CfgVp1Y: vp_y_q[1] <= cfg_data_i;
        CfgVp2X: vp_x_q[2] <= cfg_data_i;
        CfgVp2Y: vp_y_q[2] <= cfg_data_i;
        CfgThr:  thr_q     <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  assign en[NumStg] = !v_q[NumStg] || res_o.ready;
  for (genvar k = 1; k < NumStg; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign v_in        = {v_q[NumStg-1:1], seg_i.valid};
  assign seg_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NumStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 1: segment direction and doubled midpoint offsets
  assign sum_x = DiffW'(seg_i.start_x) + DiffW'(seg_i.end_x);
  assign sum_y = DiffW'(seg_i.start_y) + DiffW'(seg_i.end_y);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_idx  <= seg_i.segment_index;
      s1_zero <= (seg_i.start_x == seg_i.end_x) && (seg_i.start_y == seg_i.end_y);
      s1_dx   <= DiffW'(seg_i.start_x) - DiffW'(seg_i.end_x);
      s1_dy   <= DiffW'(seg_i.start_y) - DiffW'(seg_i.end_y);
      for (int j = 0; j < NumVp; j++) begin
        s1_wx[j] <= $signed({vp_x_q[j][VpW-1], vp_x_q[j], 1'b0})
                  - $signed({{(WvW-DiffW){1'b0}}, sum_x});
        s1_wy[j] <= $signed({vp_y_q[j][VpW-1], vp_y_q[j], 1'b0})
                  - $signed({{(WvW-DiffW){1'b0}}, sum_y});
      end
    end
  end

  // Stage 2: dot product terms and squares
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_idx  <= s1_idx;
      s2_zero <= s1_zero;
      for (int j = 0; j < NumVp; j++) begin
        s2_pxa[j]  <= ProdW'(s1_dx) * ProdW'(s1_wx[j]);
        s2_pya[j]  <= ProdW'(s1_dy) * ProdW'(s1_wy[j]);
        s2_sqx[j]  <= SqW'(s1_wx[j]) * SqW'(s1_wx[j]);
        s2_sqy[j]  <= SqW'(s1_wy[j]) * SqW'(s1_wy[j]);
        s2_skip[j] <= (s1_wx[j] == '0) && (s1_wy[j] == '0);
      end
      s2_dx2 <= DsqW'(s1_dx) * DsqW'(s1_dx);
      s2_dy2 <= DsqW'(s1_dy) * DsqW'(s1_dy);
      s2_t2  <= T2W'(thr_q) * T2W'(thr_q);
    end
  end

  // Stage 3: sum dot products and squared lengths
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_idx  <= s2_idx;
      s3_zero <= s2_zero;
      s3_skip <= s2_skip;
      for (int j = 0; j < NumVp; j++) begin
        s3_p[j] <= DotW'(s2_pxa[j]) + DotW'(s2_pya[j]);
        s3_q[j] <= QW'(s2_sqx[j]) + QW'(s2_sqy[j]);
      end
      s3_d2 <= D2W'(s2_dx2) + D2W'(s2_dy2);
      s3_t2 <= s2_t2;
    end
  end

  // Stage 4: dot magnitude and threshold scale
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_idx  <= s3_idx;
      s4_zero <= s3_zero;
      s4_skip <= s3_skip;
      for (int j = 0; j < NumVp; j++) begin
        s4_pm[j] <= s3_p[j][DotW-1] ? MagW'(-s3_p[j]) : MagW'(s3_p[j]);
        s4_q[j]  <= s3_q[j];
      end
      s4_td <= TdW'(s3_t2) * TdW'(s3_d2);
    end
  end

  // Stage 5: split squares of the dot magnitude
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_idx  <= s4_idx;
      s5_zero <= s4_zero;
      s5_skip <= s4_skip;
      s5_td   <= s4_td;
      for (int j = 0; j < NumVp; j++) begin
        s5_ll[j] <= (2*PLoW)'(s4_pm[j][PLoW-1:0]) * (2*PLoW)'(s4_pm[j][PLoW-1:0]);
        s5_lh[j] <= (PLoW+PHiW)'(s4_pm[j][PLoW-1:0])
                  * (PLoW+PHiW)'(s4_pm[j][MagW-1:PLoW]);
        s5_hh[j] <= (2*PHiW)'(s4_pm[j][MagW-1:PLoW])
                  * (2*PHiW)'(s4_pm[j][MagW-1:PLoW]);
        s5_q[j]  <= s4_q[j];
      end
    end
  end

  // Stage 6: combine dot squares
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      c6_q.idx  <= s5_idx;
      c6_q.zero <= s5_zero;
      c6_q.skip <= s5_skip;
      c6_q.td   <= s5_td;
      for (int j = 0; j < NumVp; j++) begin
        c6_q.p2[j] <= (P2W'(s5_hh[j]) << (2*PLoW)) + (P2W'(s5_lh[j]) << (PLoW+1))
                    + P2W'(s5_ll[j]);
        c6_q.q[j]  <= s5_q[j];
      end
    end
  end

  // Stages 7 and 8: cross products of points one and zero
  lvpc_wide_mul u_mul_a (
    .clk_i   (clk_i),
    .en_pp_i (en[7]),
    .en_sum_i(en[8]),
    .a_i     (c6_q.p2[1]),
    .b_i     (c6_q.q[0]),
    .prod_o  (prod_a)
  );

  lvpc_wide_mul u_mul_b (
    .clk_i   (clk_i),
    .en_pp_i (en[7]),
    .en_sum_i(en[8]),
    .a_i     (c6_q.p2[0]),
    .b_i     (c6_q.q[1]),
    .prod_o  (prod_b)
  );

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      c7_q <= c6_q;
    end
    if (en[8]) begin
      c8_q <= c7_q;
    end
  end

  // Stage 9: pick the better of points zero and one
  always_comb begin
    gt01  = prod_a > prod_b;
    take1 = !c8_q.skip[1] && (c8_q.skip[0] || gt01);
    b9_d.idx   = c8_q.idx;
    b9_d.zero  = c8_q.zero;
    b9_d.have  = !c8_q.skip[0] || !c8_q.skip[1];
    b9_d.best  = take1 ? Vp1 : Vp0;
    b9_d.p2b   = take1 ? c8_q.p2[1] : c8_q.p2[0];
    b9_d.qb    = take1 ? c8_q.q[1] : c8_q.q[0];
    b9_d.p2c   = c8_q.p2[2];
    b9_d.qc    = c8_q.q[2];
    b9_d.skipc = c8_q.skip[2];
    b9_d.td    = c8_q.td;
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      b9_q <= b9_d;
    end
  end

  // Stages 10 and 11: cross products against point two
  lvpc_wide_mul u_mul_c (
    .clk_i   (clk_i),
    .en_pp_i (en[10]),
    .en_sum_i(en[11]),
    .a_i     (b9_q.p2c),
    .b_i     (b9_q.qb),
    .prod_o  (prod_c)
  );

  lvpc_wide_mul u_mul_d (
    .clk_i   (clk_i),
    .en_pp_i (en[10]),
    .en_sum_i(en[11]),
    .a_i     (b9_q.p2b),
    .b_i     (b9_q.qc),
    .prod_o  (prod_d)
  );

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      b10_q <= b9_q;
    end
    if (en[11]) begin
      b11_q <= b10_q;
    end
  end

  // Stage 12: let point two replace the best on a strict win
  always_comb begin
    gt2   = prod_c > prod_d;
    take2 = !b11_q.skipc && (!b11_q.have || gt2);
    f12_d.idx  = b11_q.idx;
    f12_d.zero = b11_q.zero;
    f12_d.have = b11_q.have || !b11_q.skipc;
    f12_d.best = take2 ? Vp2 : b11_q.best;
    f12_d.p2b  = take2 ? b11_q.p2c : b11_q.p2b;
    f12_d.qb   = take2 ? b11_q.qc : b11_q.qb;
    f12_d.td   = b11_q.td;
  end

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      f12_q <= f12_d;
    end
  end

  // Stages 13 and 14: threshold side, T^2 * |d|^2 * |w|^2
  lvpc_wide_mul u_mul_e (
    .clk_i   (clk_i),
    .en_pp_i (en[13]),
    .en_sum_i(en[14]),
    .a_i     (MulAW'(f12_q.td)),
    .b_i     (f12_q.qb),
    .prod_o  (prod_e)
  );

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      f13_q <= f12_q;
    end
    if (en[14]) begin
      f14_q <= f13_q;
    end
  end

  // Stage 15: threshold compare into the output register
  assign lhs = MulPW'({f14_q.p2b, {(2*ThrFrac){1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en[15]) begin
      s15_idx      <= f14_q.idx;
      s15_assigned <= f14_q.have && !f14_q.zero && (lhs > prod_e);
      s15_cluster  <= (f14_q.have && !f14_q.zero) ? f14_q.best : Vp0;
    end
  end

  assign res_o.valid        = v_q[NumStg];
  assign res_o.result_index = s15_idx;
  assign res_o.assigned     = s15_assigned;
  assign res_o.cluster      = s15_cluster;

  // Checks
  `LVPC_ASSERT(a_stall_full, !seg_i.ready |-> ((&v_q) && !res_o.ready), "input held without a full pipeline")
  `LVPC_ASSERT(a_thr_reset, $rose(rst_ni) |-> (thr_q == ThrReset), "threshold not at its reset value")
  `LVPC_ASSERT(a_cluster_range, res_o.valid |-> (res_o.cluster != 2'd3), "cluster out of range")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  import lvpc_pkg::*;

  typedef logic [255:0] wide_t;

  typedef struct packed {
    logic [IdxW-1:0]     idx;
    logic                assigned;
    logic [ClusterW-1:0] cluster;
  } verdict_t;

  // Index past the register list; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgNone = 3'd7;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lvpc_seg_if seg_if ();
  lvpc_res_if res_if ();

  line_vanishing_point_classifier_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .seg_i       (seg_if),
    .res_o       (res_if)
  );

  // Local copy of the configuration
  logic signed [VpW-1:0] vp_x_q [NumVp];
  logic signed [VpW-1:0] vp_y_q [NumVp];
  logic [ThrW-1:0] thr_q;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int cycles = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_cycles = 0;

  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0d] %s mismatch: got %0d, expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Best vanishing point by exact cross-multiplied cosine squares
  function automatic verdict_t classify_segment(input logic [CoordW-1:0] x1, y1, x2, y2,
                                                input logic [IdxW-1:0] idx);
    longint dx, dy, wx, wy, dot;
    wide_t p2, q, best_p2, best_q, lhs, rhs, mag, mx, my;
    bit have_best;
    int best;
    verdict_t v;
    dx = longint'(x1) - longint'(x2);
    dy = longint'(y1) - longint'(y2);
    have_best = 1'b0;
    best = 0;
    best_p2 = '0;
    best_q = '0;
    v.idx = idx;
    v.assigned = 1'b0;
    v.cluster = Vp0;
    if (dx != 0 || dy != 0) begin
      for (int j = 0; j < NumVp; j++) begin
        wx = 2 * longint'(vp_x_q[j]) - (longint'(x1) + longint'(x2));
        wy = 2 * longint'(vp_y_q[j]) - (longint'(y1) + longint'(y2));
        if (wx == 0 && wy == 0) continue;
        dot = dx * wx + dy * wy;
        mag = wide_t'(dot < 0 ? -dot : dot);
        mx = wide_t'(wx < 0 ? -wx : wx);
        my = wide_t'(wy < 0 ? -wy : wy);
        p2 = mag * mag;
        q = mx * mx + my * my;
        if (!have_best || (p2 * best_q > best_p2 * q)) begin
          have_best = 1'b1;
          best = j;
          best_p2 = p2;
          best_q = q;
        end
      end
      if (have_best) begin
        lhs = best_p2 << ThrFrac * 2;
        rhs = wide_t'(thr_q) * wide_t'(thr_q) * wide_t'(dx * dx + dy * dy) * best_q;
        v.assigned = lhs > rhs;
        v.cluster = best[ClusterW-1:0];
      end
    end
    return v;
  endfunction

  // Write one register; caller lowers the enable with cfg_release
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgVp0X: vp_x_q[0] = data;
      CfgVp0Y: vp_y_q[0] = data;
      CfgVp1X: vp_x_q[1] = data;
      CfgVp1Y: vp_y_q[1] = data;
      CfgVp2X: vp_x_q[2] = data;
      CfgVp2Y: vp_y_q[2] = data;
      CfgThr:  thr_q = data[ThrW-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop the offer, then hold until every expected result is back
  task automatic drain();
    seg_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_points(input int x0, y0, x1, y1, x2, y2);
    drain();
    cfg_write(CfgVp0X, x0);
    cfg_write(CfgVp0Y, y0);
    cfg_write(CfgVp1X, x1);
    cfg_write(CfgVp1Y, y1);
    cfg_write(CfgVp2X, x2);
    cfg_write(CfgVp2Y, y2);
    cfg_release();
  endtask

  task automatic set_threshold(input logic [CfgDataW-1:0] thr);
    drain();
    cfg_write(CfgThr, thr);
    cfg_release();
  endtask

  // Offer one segment item and record its expected verdict on acceptance
  task automatic send_segment(input logic [CoordW-1:0] x1, y1, x2, y2,
                              input logic [IdxW-1:0] idx);
    int gap;
    gap = tx_idle_en ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      seg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    seg_if.valid <= 1'b1;
    seg_if.start_x <= x1;
    seg_if.start_y <= y1;
    seg_if.end_x <= x2;
    seg_if.end_y <= y2;
    seg_if.segment_index <= idx;
    do @(negedge clk_i); while (!seg_if.ready);
    @(posedge clk_i);
    pending_verdicts.insert(pending_verdicts.size(), classify_segment(x1, y1, x2, y2, idx));
  endtask

  task automatic send_random();
    send_segment($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [CoordW-1:0] clamp_coord(input longint c);
    if (c < 0) return '0;
    if (c > 65535) return '1;
    return c[CoordW-1:0];
  endfunction

  // Segment aimed roughly at one vanishing point, with a little jitter
  task automatic send_aimed();
    int j;
    longint mx, my, ddx, ddy, norm, len, ox, oy;
    j = $urandom_range(NumVp - 1, 0);
    mx = $urandom_range(65535, 0);
    my = $urandom_range(65535, 0);
    ddx = longint'(vp_x_q[j]) - mx;
    ddy = longint'(vp_y_q[j]) - my;
    norm = (ddx < 0 ? -ddx : ddx) > (ddy < 0 ? -ddy : ddy) ? (ddx < 0 ? -ddx : ddx)
                                                            : (ddy < 0 ? -ddy : ddy);
    if (norm == 0) begin
      send_random();
      return;
    end
    len = $urandom_range(4000, 16);
    ox = ddx * len / norm / 2;
    oy = ddy * len / norm / 2;
    send_segment(clamp_coord(mx - ox + $urandom_range(3, 0)),
                 clamp_coord(my - oy + $urandom_range(3, 0)),
                 clamp_coord(mx + ox - $urandom_range(3, 0)),
                 clamp_coord(my + oy - $urandom_range(3, 0)), $urandom);
  endtask

  // Result side: stall at random, then compare against the oldest verdict
  initial begin
    verdict_t want;
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(9, 0) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(negedge clk_i); while (res_if.valid !== 1'b1);
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result_index", res_if.result_index, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (res_if.result_index !== want.idx)
          report_mismatch("result_index", res_if.result_index, want.idx);
        if (res_if.assigned !== want.assigned)
          report_mismatch("assigned", res_if.assigned, want.assigned);
        if (res_if.cluster !== want.cluster)
          report_mismatch("cluster", res_if.cluster, want.cluster);
      end
      @(posedge clk_i);
    end
  end

  // Reset defaults: all points at the origin, six degree threshold
  task automatic test_reset_defaults();
    send_segment(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    send_segment(16'd10, 16'd10, 16'd20, 16'd20, 16'd2);
    send_segment(16'd0, 16'd0, 16'd200, 16'd10, 16'd3);
  endtask

  // Directed corners: zero length, midpoint hits, ties, extremes
  task automatic test_corners();
    set_points(250, 200, 50, 200, 150, 100);
    // tie between the first two, third sits on the midpoint
    send_segment(16'd100, 16'd100, 16'd200, 16'd100, 16'h0000);
    send_segment(16'd300, 16'd300, 16'd300, 16'd300, 16'hffff);
    // every point at the midpoint
    set_points(150, 100, 150, 100, 150, 100);
    send_segment(16'd100, 16'd100, 16'd200, 16'd100, 16'h5555);
    // collinear segment, exact cosine of one
    set_points(1000, 100, 150, 5000, -4000, 100);
    send_segment(16'd100, 16'd100, 16'd200, 16'd100, 16'haaaa);
    send_segment(16'd0, 16'd0, 16'hffff, 16'hffff, 16'h00ff);
    send_segment(16'hffff, 16'hffff, 16'd0, 16'd0, 16'hff00);
    send_segment(16'hffff, 16'd0, 16'd0, 16'hffff, 16'h0f0f);
    set_threshold(32'd32768);
    send_segment(16'd100, 16'd100, 16'd200, 16'd100, 16'h1234);
    set_threshold(32'd0);
    send_segment(16'd100, 16'd100, 16'd100, 16'd900, 16'h4321);
    send_segment(16'd100, 16'd100, 16'd200, 16'd100, 16'h2468);
    set_threshold(32'hffff_ffff);
    send_segment(16'd100, 16'd100, 16'd200, 16'd100, 16'h1357);
    // points at the register extremes
    set_points(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
               32'hffff_ffff, 32'h0000_0000);
    set_threshold(32'd32589);
    send_segment(16'hffff, 16'd0, 16'd0, 16'hffff, 16'h8001);
    send_segment(16'd0, 16'hffff, 16'hffff, 16'd0, 16'h7ffe);
    send_segment(16'd0, 16'd0, 16'd1, 16'd0, 16'h3c3c);
    // a write to an index past the list changes nothing
    drain();
    cfg_write(CfgNone, 32'h0000_0001);
    cfg_release();
    send_segment(16'd0, 16'd0, 16'hffff, 16'hffff, 16'hc3c3);
  endtask

  // Random phases: random points, thresholds and idling
  task automatic test_random_mix();
    int pts [6];
    for (int ph = 0; ph < 12; ph++) begin
      for (int k = 0; k < 6; k++)
        pts[k] = (ph % 4 == 3) ? int'($urandom) : int'($urandom_range(500000, 0)) - 200000;
      set_points(pts[0], pts[1], pts[2], pts[3], pts[4], pts[5]);
      case (ph % 4)
        0: set_threshold(32'd32589);
        1: set_threshold($urandom_range(32768, 30000));
        2: set_threshold($urandom_range(65535, 0));
        default: set_threshold($urandom_range(32767, 32700));
      endcase
      tx_idle_en = (ph % 3 != 1);
      rx_idle_en = (ph % 3 != 2);
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(9, 0) < 7) send_aimed();
        else send_random();
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Long receiver stall while the sender keeps offering items
  task automatic test_backpressure();
    drain();
    tx_idle_en = 1'b0;
    rx_hold_cycles = 300;
    for (int n = 0; n < 80; n++) send_aimed();
    tx_idle_en = 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CfgVp0X;
    cfg_data_i <= '0;
    seg_if.valid <= 1'b0;
    seg_if.start_x <= '0;
    seg_if.start_y <= '0;
    seg_if.end_x <= '0;
    seg_if.end_y <= '0;
    seg_if.segment_index <= '0;
    for (int j = 0; j < NumVp; j++) begin
      vp_x_q[j] = '0;
      vp_y_q[j] = '0;
    end
    thr_q = ThrReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_corners();
    test_random_mix();
    test_backpressure();

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

### line_vanishing_point_classifier_top.f
+incdir+rtl/core
rtl/core/lvpc_pkg.sv
rtl/core/lvpc_if.sv
rtl/core/lvpc_wide_mul.sv
rtl/core/line_vanishing_point_classifier_top.sv
tb/sv/tb_top.sv
